// ===== design/cmsf_pkg.sv =====
`default_nettype none

package cmsf_pkg;

  // Configuration port
  localparam int CFG_INDEX_BITS    = 4;
  localparam int CFG_DATA_BITS     = 16;
  localparam int ROW_COUNT_BITS    = 16;
  localparam int COLUMN_COUNT_BITS = 11;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_ROW_COUNT    = 4'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_COLUMN_COUNT = 4'd1;

  localparam logic [ROW_COUNT_BITS-1:0]    ROW_COUNT_RESET    = 16'd1024;
  localparam logic [COLUMN_COUNT_BITS-1:0] COLUMN_COUNT_RESET = 11'd1024;

  // Queue between front and back
  localparam int QUEUE_DEPTH      = 2;
  localparam int QUEUE_PTR_BITS   = 1;
  localparam int QUEUE_COUNT_BITS = 2;

  // Quotient bits resolved per divider stage
  localparam int DIV_STEPS = 8;

  typedef struct packed {
    logic has_above;  // carries the filtered sample of the row above
    logic has_self;   // final row: the input itself follows
    logic done;       // the self result closes the map
  } cmsf_flags_t;

endpackage

`default_nettype wire

// ===== design/cmsf_front.sv =====
`default_nettype none

module cmsf_front #(
  parameter int MAX_COLUMNS = 1024,
  parameter int SAMPLE_BITS = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [cmsf_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [cmsf_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [SAMPLE_BITS-1:0]        height_in,
  output logic                                 push_valid,
  input  logic                                 push_ready,
  output cmsf_pkg::cmsf_flags_t                push_flags,
  output logic [SAMPLE_BITS-1:0]               push_x,
  output logic [SAMPLE_BITS+2:0]               push_sum
);
  import cmsf_pkg::*;

  localparam int COL_BITS = $clog2(MAX_COLUMNS);
  localparam int SUM_BITS = SAMPLE_BITS + 3;

  function automatic logic [COL_BITS-1:0] col_limit(
    input logic [COLUMN_COUNT_BITS-1:0] v
  );
    int unsigned n;
    n = 32'(v);
    if (n == 0) n = 1;
    if (n > int'(MAX_COLUMNS)) n = MAX_COLUMNS;
    return COL_BITS'(n - 1);
  endfunction

  function automatic logic [ROW_COUNT_BITS-1:0] row_limit(
    input logic [ROW_COUNT_BITS-1:0] v
  );
    if (v == '0) return '0;
    return v - ROW_COUNT_BITS'(1);
  endfunction

  // offset binary: signed range maps onto unsigned, sums stay nonnegative
  function automatic logic [SAMPLE_BITS-1:0] flip(input logic [SAMPLE_BITS-1:0] v);
    return {~v[SAMPLE_BITS-1], v[SAMPLE_BITS-2:0]};
  endfunction

  logic [ROW_COUNT_BITS-1:0] last_row;
  logic [COL_BITS-1:0]       last_col;
  logic [ROW_COUNT_BITS-1:0] row_pos;
  logic [COL_BITS-1:0]       col_pos;

  logic [SAMPLE_BITS-1:0] older_mem [MAX_COLUMNS];
  logic [SAMPLE_BITS-1:0] prev_mem  [MAX_COLUMNS];
  logic [SAMPLE_BITS-1:0] mem_q_older;
  logic [SAMPLE_BITS-1:0] mem_q_prev;
  logic [SAMPLE_BITS-1:0] prior_centre;

  logic                   s1_valid;
  logic [SAMPLE_BITS-1:0] s1_up;
  logic [SAMPLE_BITS-1:0] s1_left;
  logic [SAMPLE_BITS-1:0] s1_centre;
  logic [SAMPLE_BITS-1:0] s1_down;
  logic                   s1_border;
  cmsf_flags_t            s1_flags;

  logic                  cfg_write;
  logic                  accept;
  logic                  s1_adv;
  logic                  last_col_hit;
  logic                  final_row;
  logic                  border;
  cmsf_flags_t           flags;
  logic [COL_BITS-1:0]   col_next;
  logic [ROW_COUNT_BITS-1:0] row_next;
  logic [SUM_BITS-1:0]   cross_sum;
  logic [SUM_BITS-1:0]   centre5;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid & cfg_ready;

  assign s1_adv   = s1_valid & push_ready;
  assign in_ready = ~s1_valid | push_ready;
  assign accept   = in_valid & in_ready;

  always_comb begin
    last_col_hit    = (col_pos == last_col);
    final_row       = (row_pos == last_row);
    border          = (row_pos == ROW_COUNT_BITS'(1)) || (col_pos == '0) || last_col_hit;
    flags.has_above = (row_pos != '0);
    flags.has_self  = final_row;
    flags.done      = final_row & last_col_hit;
    col_next        = last_col_hit ? '0 : col_pos + COL_BITS'(1);
    if (!last_col_hit) begin
      row_next = row_pos;
    end else if (final_row) begin
      row_next = '0;
    end else begin
      row_next = row_pos + ROW_COUNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_row <= row_limit(ROW_COUNT_RESET);
      last_col <= col_limit(COLUMN_COUNT_RESET);
      row_pos  <= '0;
      col_pos  <= '0;
      s1_valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_ROW_COUNT: begin
            last_row <= row_limit(cfg_data[ROW_COUNT_BITS-1:0]);
            row_pos  <= '0;
            col_pos  <= '0;
          end
          CFG_COLUMN_COUNT: begin
            last_col <= col_limit(cfg_data[COLUMN_COUNT_BITS-1:0]);
            row_pos  <= '0;
            col_pos  <= '0;
          end
          default: ;
        endcase
      end else if (accept) begin
        row_pos <= row_next;
        col_pos <= col_next;
      end
      if (accept) begin
        // row 0 of a taller map gives nothing: drop it here
        s1_valid <= flags.has_above | flags.has_self;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_up        <= mem_q_older;
      s1_left      <= prior_centre;
      s1_centre    <= mem_q_prev;
      s1_down      <= height_in;
      s1_border    <= border;
      s1_flags     <= flags;
      prior_centre <= mem_q_prev;
    end
  end

  // Line buffers: rotate column col_pos, prefetch the next column's word
  always_ff @(posedge clk) begin
    if (accept) begin
      older_mem[col_pos] <= mem_q_prev;
      prev_mem[col_pos]  <= height_in;
      if (col_next == col_pos) begin
        mem_q_older <= mem_q_prev;
        mem_q_prev  <= height_in;
      end else begin
        mem_q_older <= older_mem[col_next];
        mem_q_prev  <= prev_mem[col_next];
      end
    end
  end

  // right neighbor arrives from the prefetch while the item sits in s1
  always_comb begin
    cross_sum = SUM_BITS'(flip(s1_up)) + SUM_BITS'(flip(s1_left))
              + SUM_BITS'(flip(s1_centre)) + SUM_BITS'(flip(mem_q_prev))
              + SUM_BITS'(flip(s1_down));
    centre5   = (SUM_BITS'(flip(s1_centre)) << 2) + SUM_BITS'(flip(s1_centre));
  end

  assign push_valid = s1_valid;
  assign push_flags = s1_flags;
  assign push_x     = s1_down;
  assign push_sum   = s1_border ? centre5 : cross_sum;

endmodule

`default_nettype wire

// ===== design/cmsf_queue.sv =====
`default_nettype none

module cmsf_queue #(
  parameter int DATA_BITS = 67
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push_valid,
  output logic                  push_ready,
  input  cmsf_pkg::cmsf_flags_t push_flags,
  input  logic [DATA_BITS-1:0]  push_data,
  output logic                  pop_valid,
  input  logic                  pop_ready,
  output cmsf_pkg::cmsf_flags_t pop_flags,
  output logic [DATA_BITS-1:0]  pop_data
);
  import cmsf_pkg::*;

  cmsf_flags_t               entry_flags [QUEUE_DEPTH];
  logic [DATA_BITS-1:0]      entry_data  [QUEUE_DEPTH];
  logic [QUEUE_PTR_BITS-1:0] wr_ptr;
  logic [QUEUE_PTR_BITS-1:0] rd_ptr;
  logic [QUEUE_COUNT_BITS-1:0] count;

  logic push;
  logic pop;

  assign push_ready = (count != QUEUE_COUNT_BITS'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid & push_ready;
  assign pop        = pop_valid & pop_ready;
  assign pop_flags  = entry_flags[rd_ptr];
  assign pop_data   = entry_data[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                : wr_ptr + QUEUE_PTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                : rd_ptr + QUEUE_PTR_BITS'(1);
      end
      if (push && !pop) begin
        count <= count + QUEUE_COUNT_BITS'(1);
      end else if (pop && !push) begin
        count <= count - QUEUE_COUNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_flags[wr_ptr] <= push_flags;
      entry_data[wr_ptr]  <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== design/cmsf_back.sv =====
`default_nettype none

module cmsf_back #(
  parameter int SAMPLE_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         pop_valid,
  output logic                         pop_ready,
  input  cmsf_pkg::cmsf_flags_t        pop_flags,
  input  logic [SAMPLE_BITS-1:0]       pop_x,
  input  logic [SAMPLE_BITS+2:0]       pop_sum,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [SAMPLE_BITS-1:0] height_out,
  output logic                         map_done
);
  import cmsf_pkg::*;

  localparam int SUM_BITS = SAMPLE_BITS + 3;
  localparam int NSTAGE   = (SUM_BITS + DIV_STEPS - 1) / DIV_STEPS;
  localparam int PAD_BITS = NSTAGE * DIV_STEPS;
  localparam int LAST     = NSTAGE - 1;

  typedef struct packed {
    logic [2:0]          rem;
    logic [PAD_BITS-1:0] work;  // dividend bits shift out on top, quotient bits in below
  } div_state_t;

  // restoring division by five, DIV_STEPS quotient bits
  function automatic div_state_t div_steps(input div_state_t s);
    div_state_t r;
    logic [3:0] t;
    r = s;
    for (int k = 0; k < DIV_STEPS; k++) begin
      t = {r.rem, r.work[PAD_BITS-1]};
      if (t >= 4'd5) begin
        r.rem  = 3'(t - 4'd5);
        r.work = {r.work[PAD_BITS-2:0], 1'b1};
      end else begin
        r.rem  = t[2:0];
        r.work = {r.work[PAD_BITS-2:0], 1'b0};
      end
    end
    return r;
  endfunction

  logic                   stg_valid    [NSTAGE];
  div_state_t             stg_div      [NSTAGE];
  logic [SAMPLE_BITS-1:0] stg_x        [NSTAGE];
  cmsf_flags_t            stg_flags    [NSTAGE];
  logic                   stg_ready    [NSTAGE];
  logic                   stg_in_valid [NSTAGE];
  div_state_t             stg_in_div   [NSTAGE];
  logic [SAMPLE_BITS-1:0] stg_in_x     [NSTAGE];
  cmsf_flags_t            stg_in_flags [NSTAGE];

  logic                   pend_valid;
  logic [SAMPLE_BITS-1:0] pend_x;
  logic                   pend_done;

  logic                   slot_free;
  logic                   take_pend;
  logic                   take_item;
  logic [SAMPLE_BITS-1:0] quot;
  logic [SAMPLE_BITS-1:0] above_val;

  assign slot_free = ~out_valid | out_ready;
  assign take_pend = slot_free & pend_valid;
  assign take_item = slot_free & ~pend_valid & stg_valid[LAST];

  assign quot      = stg_div[LAST].work[SAMPLE_BITS-1:0];
  assign above_val = {~quot[SAMPLE_BITS-1], quot[SAMPLE_BITS-2:0]};

  always_comb begin
    stg_ready[LAST] = ~stg_valid[LAST] | take_item;
    for (int i = LAST - 1; i >= 0; i--) begin
      stg_ready[i] = ~stg_valid[i] | stg_ready[i+1];
    end
    stg_in_valid[0] = pop_valid;
    stg_in_div[0]   = div_steps({3'd0, PAD_BITS'(pop_sum)});
    stg_in_x[0]     = pop_x;
    stg_in_flags[0] = pop_flags;
    for (int i = 1; i < NSTAGE; i++) begin
      stg_in_valid[i] = stg_valid[i-1];
      stg_in_div[i]   = div_steps(stg_div[i-1]);
      stg_in_x[i]     = stg_x[i-1];
      stg_in_flags[i] = stg_flags[i-1];
    end
  end

  assign pop_ready = stg_ready[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NSTAGE; i++) begin
        stg_valid[i] <= 1'b0;
      end
    end else begin
      for (int i = 0; i < NSTAGE; i++) begin
        if (stg_ready[i]) begin
          stg_valid[i] <= stg_in_valid[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NSTAGE; i++) begin
      if (stg_ready[i] && stg_in_valid[i]) begin
        stg_div[i]   <= stg_in_div[i];
        stg_x[i]     <= stg_in_x[i];
        stg_flags[i] <= stg_in_flags[i];
      end
    end
  end

  // above result first, then the input itself on the final row
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      if (take_pend) begin
        out_valid  <= 1'b1;
        height_out <= pend_x;
        map_done   <= pend_done;
        pend_valid <= 1'b0;
      end else if (take_item) begin
        out_valid <= 1'b1;
        if (stg_flags[LAST].has_above) begin
          height_out <= above_val;
          map_done   <= 1'b0;
          pend_valid <= stg_flags[LAST].has_self;
          pend_x     <= stg_x[LAST];
          pend_done  <= stg_flags[LAST].done;
        end else begin
          height_out <= stg_x[LAST];
          map_done   <= stg_flags[LAST].done;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/cross_mean_smoothing_filter.sv =====
// Channel   Handshake              Payload
// cfg       cfg_valid / cfg_ready  cfg_index (0 row_count, 1 column_count), cfg_data
// in        in_valid / in_ready    height_in, signed Q16.16, raster order
// out       out_valid / out_ready  height_out, map_done
//
// One sample per cycle in steady state while the output is not stalled; on the final
// row of a map with two or more rows each sample yields two results through the
// single output register, so that row takes samples at a lower rate.
// An input reaches its result through the front stage, the queue,
// ceil((SAMPLE_BITS+3)/8) divider stages and the output register.
// Reset clears control only; line buffers hold nothing valid until the first
// row of a map has passed, and no clearing pass runs.
// A stalled output fills the divider stages and the two-entry queue before
// in_ready drops. cfg_ready is always high.
`default_nettype none

module cross_mean_smoothing_filter #(
  parameter int MAX_COLUMNS = 1024,
  parameter int SAMPLE_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [cmsf_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [cmsf_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [SAMPLE_BITS-1:0]       height_in,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [SAMPLE_BITS-1:0]       height_out,
  output logic                                map_done
);
  import cmsf_pkg::*;

  localparam int SUM_BITS  = SAMPLE_BITS + 3;
  localparam int DATA_BITS = SAMPLE_BITS + SUM_BITS;

  logic                   q_push_valid;
  logic                   q_push_ready;
  cmsf_flags_t            q_push_flags;
  logic [SAMPLE_BITS-1:0] q_push_x;
  logic [SUM_BITS-1:0]    q_push_sum;
  logic                   q_pop_valid;
  logic                   q_pop_ready;
  cmsf_flags_t            q_pop_flags;
  logic [DATA_BITS-1:0]   q_pop_data;

  cmsf_front #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .height_in  (height_in),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_flags (q_push_flags),
    .push_x     (q_push_x),
    .push_sum   (q_push_sum)
  );

  cmsf_queue #(
    .DATA_BITS (DATA_BITS)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_flags (q_push_flags),
    .push_data  ({q_push_x, q_push_sum}),
    .pop_valid  (q_pop_valid),
    .pop_ready  (q_pop_ready),
    .pop_flags  (q_pop_flags),
    .pop_data   (q_pop_data)
  );

  cmsf_back #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .pop_valid  (q_pop_valid),
    .pop_ready  (q_pop_ready),
    .pop_flags  (q_pop_flags),
    .pop_x      (q_pop_data[DATA_BITS-1:SUM_BITS]),
    .pop_sum    (q_pop_data[SUM_BITS-1:0]),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .height_out (height_out),
    .map_done   (map_done)
  );

`ifndef ASSERT_OFF
  // queue entries leave only by a pop transaction
  a_queue_no_drop: assert property (@(posedge clk) disable iff (rst)
    $fell(q_pop_valid) |-> $past(q_pop_ready) || $past(rst))
    else $error("queue entry vanished without a pop");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> in_ready && !out_valid)
    else $error("block not idle after reset");

  // input stalls only behind a front entry the queue cannot take
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> q_push_valid && !q_push_ready)
    else $error("input stalled without queue backpressure");
`endif

endmodule

`default_nettype wire
